@@ rtl/chp_pkg.sv @@
// package for the call-site hit profiler: payload structs, widths, op codes
// no dependencies
package chp_pkg;
  localparam int DefMaxSites = 64;
  localparam int CntW = 7;
  localparam logic OpLoad = 1'b0;
  localparam logic OpHit = 1'b1;
  localparam logic [31:0] SatMax = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        operation;
    logic [5:0]  entry_slot;
    logic [31:0] address;
    logic [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  site_index;
    logic [31:0] total_hits;
    logic [31:0] first_tick;
    logic [31:0] active_ticks;
    logic [31:0] peak_tick_hits;
    logic [31:0] current_tick_hits;
    logic [31:0] repeat_tick_hits;
    logic [31:0] gap_one_count;
    logic [31:0] gap_two_count;
    logic [31:0] gap_long_count;
    logic [31:0] unknown_count;
  } out_item_t;

  // per-entry statistics record, stored as one memory word
  typedef struct packed {
    logic [31:0] hits;
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] active;
    logic [31:0] peak;
    logic [31:0] tick;
    logic [31:0] rep;
    logic [31:0] g1;
    logic [31:0] g2;
    logic [31:0] gl;
  } stats_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v != SatMax) ? v + 32'd1 : v;
  endfunction
endpackage

@@ rtl/chp_ram.sv @@
// generic single-port-write, single-read RAM with registered read data
// no dependencies
module chp_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/chp_fifo.sv @@
// two-entry queue between front and back
// depends on nothing but its type parameter
module chp_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  T     in_data,
  output logic out_valid,
  input  logic out_ready,
  output T     out_data
);
  T q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  assign in_ready = cnt_r != 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_data = q_r[rp_r];
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q_r[wp_r] <= in_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (out_valid && out_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end
endmodule

@@ rtl/chp_front.sv @@
// front: accepts items, binary-searches the address table, classifies
// depends on chp_pkg, chp_ram
module chp_front #(
  parameter int MaxSites = chp_pkg::DefMaxSites,
  localparam int IdxW = $clog2(MaxSites) > 0 ? $clog2(MaxSites) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [6:0]           site_count,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  chp_pkg::in_item_t    in_data,
  output logic                 q_valid,
  input  logic                 q_ready,
  // classified transaction: op, hit found, index, sample, load slot in range
  output logic                 q_hit,
  output logic                 q_found,
  output logic [IdxW-1:0]      q_idx,
  output logic [31:0]          q_sample,
  output logic                 q_load_ok
);
  import chp_pkg::*;
  localparam int NW = $clog2(MaxSites + 1);
  localparam logic [2:0] SIdle = 3'd0, SProbe = 3'd1, SWait = 3'd2,
                         SCheck = 3'd3, SCheckW = 3'd4, SOut = 3'd5;
  logic [2:0] st_r, st_nxt;
  logic [NW-1:0] lo_r, hi_r, n_r, mid;
  in_item_t it_r;
  logic found_r;
  logic we;
  logic [IdxW-1:0] raddr;
  logic [31:0] rdata;
  logic [NW:0] sum;

  assign sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid = sum[NW:1];
  assign we = in_valid && in_ready && in_data.operation == OpLoad
              && 32'(in_data.entry_slot) < 32'(MaxSites);
  assign raddr = (st_r == SCheck) ? lo_r[IdxW-1:0] : mid[IdxW-1:0];

  chp_ram #(.Width(32), .Depth(MaxSites)) u_addr (
    .clk, .we, .waddr(in_data.entry_slot[IdxW-1:0]), .wdata(in_data.address),
    .raddr, .rdata
  );

  assign in_ready = st_r == SIdle;
  assign q_valid = st_r == SOut;
  assign q_hit = it_r.operation == OpHit;
  assign q_found = found_r;
  // hits carry the search result, loads the slot to clear
  assign q_idx = q_hit ? lo_r[IdxW-1:0] : it_r.entry_slot[IdxW-1:0];
  assign q_sample = it_r.sample;
  assign q_load_ok = 32'(it_r.entry_slot) < 32'(MaxSites);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) it_r <= in_data;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SIdle:   if (in_valid) st_nxt = (in_data.operation == OpHit) ? SProbe : SOut;
      SProbe:  st_nxt = (lo_r < hi_r) ? SWait : SCheck;
      SWait:   st_nxt = SProbe;
      SCheck:  st_nxt = (lo_r < n_r) ? SCheckW : SOut;
      SCheckW: st_nxt = SOut;
      SOut:    if (q_ready) st_nxt = SIdle;
      default: st_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SIdle;
      found_r <= 1'b0;
      lo_r <= '0;
      hi_r <= '0;
      n_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        SIdle: if (in_valid) begin
          found_r <= 1'b0;
          lo_r <= '0;
          n_r <= (32'(site_count) < 32'(MaxSites)) ? NW'(site_count) : NW'(MaxSites);
          hi_r <= (32'(site_count) < 32'(MaxSites)) ? NW'(site_count) : NW'(MaxSites);
        end
        SWait: begin
          // probe data for mid is registered now
          if (rdata < it_r.address) lo_r <= mid + NW'(1);
          else hi_r <= mid;
        end
        SCheckW: found_r <= rdata == it_r.address;
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/chp_back.sv @@
// back: read-modify-write of the entry statistics and the miss counter
// depends on chp_pkg, chp_ram
module chp_back #(
  parameter int MaxSites = chp_pkg::DefMaxSites,
  localparam int IdxW = $clog2(MaxSites) > 0 ? $clog2(MaxSites) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic                 q_hit,
  input  logic                 q_found,
  input  logic [IdxW-1:0]      q_idx,
  input  logic [31:0]          q_sample,
  input  logic                 q_load_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output chp_pkg::out_item_t   out_data
);
  import chp_pkg::*;
  localparam logic [1:0] SIdle = 2'd0, SRead = 2'd1, SOut = 2'd2;
  logic [1:0] st_r;
  logic [MaxSites-1:0] vld_r;
  logic [31:0] miss_r;
  logic [IdxW-1:0] idx_r;
  logic [31:0] smp_r;
  stats_t rd, cur, upd, wdata;
  logic we;
  logic [IdxW-1:0] waddr;
  out_item_t res_r;
  logic [31:0] gap, tk;

  chp_ram #(.Width($bits(stats_t)), .Depth(MaxSites)) u_stats (
    .clk, .we, .waddr, .wdata, .raddr(q_idx), .rdata(rd)
  );

  assign q_ready = st_r == SIdle;
  assign out_valid = st_r == SOut;
  assign out_data = res_r;
  assign cur = vld_r[idx_r] ? rd : '0;
  assign gap = smp_r - cur.last;

  always_comb begin
    upd = cur;
    tk = sat_inc(cur.tick);
    if (cur.hits == '0) begin
      upd.hits = 32'd1; upd.first = smp_r; upd.active = 32'd1;
      upd.peak = 32'd1; upd.tick = 32'd1;
    end else begin
      upd.hits = sat_inc(cur.hits);
      if (smp_r == cur.last) begin
        upd.rep = sat_inc(cur.rep);
        upd.tick = tk;
        if (tk > cur.peak) upd.peak = tk;
      end else begin
        upd.active = sat_inc(cur.active);
        priority if (gap == 32'd1) upd.g1 = sat_inc(cur.g1);
        else if (gap == 32'd2) upd.g2 = sat_inc(cur.g2);
        else upd.gl = sat_inc(cur.gl);
        upd.tick = 32'd1;
      end
    end
    upd.last = smp_r;
  end

  // only hits write: the update goes in after the read; loads clear the valid bit instead
  always_comb begin
    we = 1'b0;
    waddr = idx_r;
    wdata = upd;
    if (st_r == SRead) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      idx_r <= q_idx;
      smp_r <= q_sample;
    end
    if (st_r == SRead) begin
      res_r <= '{found: 1'b1, site_index: 6'(idx_r), total_hits: upd.hits,
                 first_tick: upd.first, active_ticks: upd.active,
                 peak_tick_hits: upd.peak, current_tick_hits: upd.tick,
                 repeat_tick_hits: upd.rep, gap_one_count: upd.g1,
                 gap_two_count: upd.g2, gap_long_count: upd.gl,
                 unknown_count: miss_r};
    end else if (q_valid && q_ready) begin
      res_r <= '{found: 1'b0, site_index: 6'd0, total_hits: 32'd0,
                 first_tick: 32'd0, active_ticks: 32'd0,
                 peak_tick_hits: 32'd0, current_tick_hits: 32'd0,
                 repeat_tick_hits: 32'd0, gap_one_count: 32'd0,
                 gap_two_count: 32'd0, gap_long_count: 32'd0,
                 unknown_count: (q_hit && !q_found) ? sat_inc(miss_r) : miss_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SIdle;
      vld_r <= '0;
      miss_r <= '0;
    end else begin
      unique case (st_r)
        SIdle: if (q_valid) begin
          if (q_hit && q_found) st_r <= SRead;
          else begin
            st_r <= SOut;
            if (q_hit) miss_r <= sat_inc(miss_r);
            else if (q_load_ok) vld_r[q_idx] <= 1'b0;
          end
        end
        SRead: begin
          vld_r[idx_r] <= 1'b1;
          st_r <= SOut;
        end
        SOut: if (out_ready) st_r <= SIdle;
        default: st_r <= SIdle;
      endcase
    end
  end
endmodule

@@ rtl/callsite_hit_profiler.sv @@
// top level of the call-site hit profiler: front search, queue, back update
// depends on chp_pkg, chp_front, chp_fifo, chp_back, chp_ram
//
//  channel | direction | payload       | handshake
//  in_     | input     | in_item_t     | in_valid / in_ready
//  out_    | output    | out_item_t    | out_valid / out_ready
//  cfg_    | input     | site_count[6:0] | cfg_valid / cfg_ready (always ready)
//
// a hit holds the front through the address ram probe loop (probe, then wait for
// the registered read), then, if the final slot is in range, a check read of it,
// then the output state; a load goes from acceptance straight to the output state
// the back reads, updates and writes the entry for a site hit, and goes straight
// to its output state otherwise; front and back overlap
// statistics sit in a ram with one valid bit per entry, cleared by reset and loads
// reset is synchronous, active low; a stalled output holds the back, and the
// front stops once the two-entry queue is full
module callsite_hit_profiler #(
  parameter int MaxSites = chp_pkg::DefMaxSites
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  chp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output chp_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import chp_pkg::*;
  localparam int IdxW = $clog2(MaxSites) > 0 ? $clog2(MaxSites) : 1;
  typedef struct packed {
    logic            hit;
    logic            found;
    logic [IdxW-1:0] idx;
    logic [31:0]     sample;
    logic            load_ok;
  } cls_t;

  logic [CntW-1:0] count_r;
  cls_t f_d, b_d;
  logic f_v, f_r, b_v, b_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cfg_valid) count_r <= cfg_data;
  end

  chp_front #(.MaxSites(MaxSites)) u_front (
    .clk, .rst_n, .site_count(count_r), .in_valid, .in_ready, .in_data,
    .q_valid(f_v), .q_ready(f_r), .q_hit(f_d.hit), .q_found(f_d.found),
    .q_idx(f_d.idx), .q_sample(f_d.sample), .q_load_ok(f_d.load_ok)
  );

  chp_fifo #(.T(cls_t)) u_q (
    .clk, .rst_n, .in_valid(f_v), .in_ready(f_r), .in_data(f_d),
    .out_valid(b_v), .out_ready(b_r), .out_data(b_d)
  );

  chp_back #(.MaxSites(MaxSites)) u_back (
    .clk, .rst_n, .q_valid(b_v), .q_ready(b_r), .q_hit(b_d.hit),
    .q_found(b_d.found), .q_idx(b_d.idx), .q_sample(b_d.sample),
    .q_load_ok(b_d.load_ok), .out_valid, .out_ready, .out_data
  );
endmodule
